/* sv/phmi_pkg.sv */
// Shared types and constants of the pixel hit to module index mapper.
// Used by phmi_map and by the top level pixel_hit_to_module_index.
package phmi_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam int unsigned RegCount    = 7;
    localparam logic [2:0] REG_FAMILY   = 3'd0;
    localparam logic [2:0] REG_CPH      = 3'd1;
    localparam logic [2:0] REG_COLS     = 3'd2;
    localparam logic [2:0] REG_ROWS     = 3'd3;
    localparam logic [2:0] REG_FORWARD  = 3'd4;
    localparam logic [2:0] REG_BEC      = 3'd5;
    localparam logic [2:0] REG_PHI_EVEN = 3'd6;

    // Front-end chip families
    localparam logic [1:0] FAM_OLD = 2'd0;
    localparam logic [1:0] FAM_NEW = 2'd1;

    // Endcap codes of the barrel/endcap register
    localparam logic signed [3:0] BEC_ENDCAP_POS = 4'sd2;
    localparam logic signed [3:0] BEC_ENDCAP_NEG = -4'sd2;

    // Reset values of the first four registers (the rest reset to zero)
    localparam logic [1:0] RST_FAMILY = FAM_OLD;
    localparam logic [4:0] RST_CPH    = 5'd8;
    localparam logic [7:0] RST_COLS   = 8'd18;
    localparam logic [8:0] RST_ROWS   = 9'd320;

    // Stream payload widths (whole bytes)
    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 24;

    typedef struct packed {
        logic [1:0]        family;
        logic [4:0]        cph;
        logic [7:0]        cols;
        logic [8:0]        rows;
        logic              forward;
        logic signed [3:0] bec;
        logic              phi_even;
    } cfg_t;

    typedef struct packed {
        logic [4:0] chip_number;
        logic [8:0] hit_row;
        logic [7:0] hit_column;
    } hit_t;

    typedef struct packed {
        logic [9:0]  phi_position;
        logic [12:0] eta_position;
        logic        hit_valid;
    } res_t;

endpackage

/* sv/pixel_hit_to_module_index.sv */
// Top level of the pixel hit to module index mapper: APB registers, stream pipeline.
// Depends on phmi_pkg and phmi_map.
//
// Maps each raw pixel hit (front-end chip number, row, column on s_tdata) to the
// module-wide phi and eta indices of one configured module, returned on m_tdata with
// the valid flag on m_tuser. The module kind comes from the registers: forward,
// planar or 3D modules of the newer chip family, barrel or endcap modules of the
// older one. Rejected hits (out of range, zero index on the newer family, unsupported
// family) come out with the flag low and zero indices. Every hit gives exactly one
// result, in order. Throughput is one hit per cycle while m_tready holds; the result
// reaches m_tvalid through the input register and the result register around the
// mapping logic (one 5x8 multiply plus adds and compares). The input register keeps
// accepting while a result waits, until both stages are full.
// Registers are to be written by the user only while no hit is in flight; the block
// itself does not enforce it.
module pixel_hit_to_module_index
    import phmi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // chip_number[4:0], hit_row[13:5],
                                           // hit_column[21:14], zero fill
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // phi_position[9:0], eta_position[22:10],
                                           // zero fill
    output logic                m_tuser,   // hit_valid
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t cfg_reg, cfg_next;
    logic [2:0] reg_idx;
    logic cfg_wr;

    hit_t hit_reg;
    logic s1_valid_reg;
    res_t res_map;
    res_t res_reg;
    logic m_valid_reg;
    logic out_free;
    logic s1_load;

    // ------------------------------------------------------------------
    // Configuration registers: written on the access phase of a transfer
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_FAMILY:   cfg_next.family   = pwdata[1:0];
                REG_CPH:      cfg_next.cph      = pwdata[4:0];
                REG_COLS:     cfg_next.cols     = pwdata[7:0];
                REG_ROWS:     cfg_next.rows     = pwdata[8:0];
                REG_FORWARD:  cfg_next.forward  = pwdata[0];
                REG_BEC:      cfg_next.bec      = signed'(pwdata[3:0]);
                REG_PHI_EVEN: cfg_next.phi_even = pwdata[0];
                default:      cfg_next = cfg_reg;   // drop writes past the last register
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.family   <= RST_FAMILY;
            cfg_reg.cph      <= RST_CPH;
            cfg_reg.cols     <= RST_COLS;
            cfg_reg.rows     <= RST_ROWS;
            cfg_reg.forward  <= 1'b0;
            cfg_reg.bec      <= 4'sd0;
            cfg_reg.phi_even <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the register at the addressed index
    always_comb begin
        case (reg_idx)
            REG_FAMILY:   prdata = {30'd0, cfg_reg.family};
            REG_CPH:      prdata = {27'd0, cfg_reg.cph};
            REG_COLS:     prdata = {24'd0, cfg_reg.cols};
            REG_ROWS:     prdata = {23'd0, cfg_reg.rows};
            REG_FORWARD:  prdata = {31'd0, cfg_reg.forward};
            REG_BEC:      prdata = {28'd0, cfg_reg.bec};
            REG_PHI_EVEN: prdata = {31'd0, cfg_reg.phi_even};
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Two-stage pipeline: input register -> mapping -> result register
    // ------------------------------------------------------------------
    // Result register can take a new value when empty or being drained
    assign out_free = !m_valid_reg || m_tready;
    // Input register advances when empty or when its item moves on
    assign s_tready = !s1_valid_reg || out_free;
    assign s1_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Hold the captured hit until the next transfer replaces it
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            hit_reg.chip_number <= s_tdata[4:0];
            hit_reg.hit_row     <= s_tdata[13:5];
            hit_reg.hit_column  <= s_tdata[21:14];
        end
    end

    phmi_map u_map (
        .cfg (cfg_reg),
        .hit (hit_reg),
        .res (res_map)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // Capture the mapped result when the stage moves forward
    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            res_reg <= res_map;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg.eta_position, res_reg.phi_position};
    assign m_tuser  = res_reg.hit_valid;

`ifndef SYNTH
    // A rejected hit never carries indices
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.hit_valid) |-> (res_reg.phi_position == 10'd0
                                               && res_reg.eta_position == 13'd0))
        else $error("rejected hit carries nonzero indices");

    // An item in the input register moves to the result stage when it is free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_free) |=> m_valid_reg)
        else $error("item lost between input and result stage");

    // Backpressure only when both stages are full and the output stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled while pipeline has room");
`endif

endmodule

/* sv/phmi_map.sv */
// Combinational hit-to-index mapping for one configured module.
// Depends on phmi_pkg (cfg_t, hit_t, res_t, family codes).
module phmi_map
    import phmi_pkg::*;
(
    input  cfg_t cfg,
    input  hit_t hit,
    output res_t res
);

    logic        fam_new;
    logic        fam_old;
    logic [8:0]  row_c;
    logic [7:0]  col_c;
    logic [8:0]  rows;
    logic [9:0]  rows2;
    logic [5:0]  fe_lim;
    logic        low_half;
    logic        in_range;
    logic        endcap;
    logic        side_pos;
    logic [4:0]  mul_a;
    logic [12:0] prod;
    logic [9:0]  rows_dn;
    logic [9:0]  rows2_dn;
    logic [9:0]  phi;
    logic [12:0] eta;

    assign fam_new = (cfg.family == FAM_NEW);
    assign fam_old = (cfg.family == FAM_OLD);

    // Newer family counts from one: a raw zero wraps and is rejected below
    assign row_c = fam_new ? hit.hit_row - 9'd1 : hit.hit_row;
    assign col_c = fam_new ? hit.hit_column - 8'd1 : hit.hit_column;

    // Older family: half the designed rows plus the ganged rows
    assign rows   = fam_new ? cfg.rows : {1'b0, cfg.rows[8:1]} + 9'd4;
    assign rows2  = {rows, 1'b0};
    assign fe_lim = fam_new ? {1'b0, cfg.cph} : {cfg.cph, 1'b0};

    assign in_range = (fam_new || fam_old)
                   && !(fam_new && (hit.hit_row == 9'd0 || hit.hit_column == 8'd0))
                   && (row_c < rows)
                   && (col_c < cfg.cols)
                   && ({1'b0, hit.chip_number} < fe_lim);

    assign low_half = (hit.chip_number < cfg.cph);
    assign endcap   = fam_old && (cfg.bec == BEC_ENDCAP_POS || cfg.bec == BEC_ENDCAP_NEG);
    assign side_pos = !cfg.bec[3] && (cfg.bec != 4'sd0);

    // One shared product: chip offset times columns per chip
    always_comb begin
        if (fam_new) begin
            mul_a = hit.chip_number;
        end else if (low_half) begin
            mul_a = cfg.cph - hit.chip_number;
        end else begin
            mul_a = hit.chip_number - cfg.cph;
        end
    end

    assign prod     = {8'd0, mul_a} * {5'd0, cfg.cols};
    assign rows_dn  = {1'b0, rows} - 10'd1 - {1'b0, row_c};
    assign rows2_dn = rows2 - 10'd1 - {1'b0, row_c};

    always_comb begin
        phi = '0;
        eta = '0;
        if (fam_new && cfg.forward) begin
            eta = {3'd0, rows_dn};
            phi = side_pos ? {2'd0, col_c} : {2'd0, cfg.cols - 8'd1 - col_c};
        end else if (fam_new) begin
            phi = rows_dn;
            eta = prod + {5'd0, col_c};
        end else begin
            if (low_half) begin
                phi = rows2_dn;
                eta = prod - 13'd1 - {5'd0, col_c};
            end else begin
                phi = {1'b0, row_c};
                eta = prod + {5'd0, col_c};
            end
            // mirror phi on endcap modules in even slots
            if (endcap && cfg.phi_even) begin
                phi = rows2 - phi - 10'd1;
            end
        end
    end

    assign res.phi_position = in_range ? phi : '0;
    assign res.eta_position = in_range ? eta : '0;
    assign res.hit_valid    = in_range;

endmodule
